/* rtl/lcsp_pkg.sv */
// shared constants for the combined shuffled random source
package lcsp_pkg;

	localparam int unsigned VAL_W = 31;
	localparam int unsigned SEED_W = 32;
	localparam int unsigned PROD_W = 48;
	localparam int unsigned TABLE_DEPTH_DEF = 32;

	localparam logic [VAL_W-1:0] MOD1 = 31'd2147483563;
	localparam logic [VAL_W-1:0] MOD2 = 31'd2147483399;
	localparam logic [15:0] MUL1 = 16'd40014;
	localparam logic [15:0] MUL2 = 16'd40692;
	localparam logic [VAL_W-1:0] WRAP1 = 31'd2147483562;
	localparam logic [VAL_W-1:0] SECOND_SEED = 31'd123456789;

endpackage

/* rtl/lecuyer_combined_shuffled_prng_top.sv */
// combined two-generator random source with shuffle table, top level
//
//  channel   signals                         direction  meaning
//  request   start, busy, func, seed_value   in / out   seed (func 0) or draw (func 1)
//  result    done, rand_value                out        one drawn integer per draw
//
// a request is taken at a rising edge with start high and busy low
// draw: busy through the draw, output and slot division steps, then idle again;
//   done pulses for one cycle, registered at the output step; the table read,
//   the generator fold and the slot division of the new output form the loop
// seed: busy for the warm-up steps and the slot division, then idle again;
//   each generator step is a multiply then a fold in the shared multiply/fold unit,
//   then the slot division; no result
// reset clears generators, last output, slot and per-entry valid bits at once;
//   an entry never written reads as zero, so no clearing pass is needed
// the receiver cannot stall: done is a one-cycle strobe
module lecuyer_combined_shuffled_prng_top import lcsp_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [SEED_W-1:0] seed_value,
	output logic              done,
	output logic [VAL_W-1:0]  rand_value
);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 8);

	// request function codes
	localparam logic FN_SEED = 1'b0;
	localparam logic FN_DRAW = 1'b1;

	// sequencer states
	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_SEED_FOLD = 3'd1;
	localparam logic [2:0] ST_SEED_MUL  = 3'd2;
	localparam logic [2:0] ST_DRAW      = 3'd3;
	localparam logic [2:0] ST_DRAW_OUT  = 3'd4;
	localparam logic [2:0] ST_SLOT_GO   = 3'd5;
	localparam logic [2:0] ST_SLOT_WAIT = 3'd6;

	logic [2:0]             state_q;
	logic [VAL_W-1:0]       first_gen_q;
	logic [VAL_W-1:0]       second_gen_q;
	logic [VAL_W-1:0]       last_out_q;
	logic [IW-1:0]          slot_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   rd_valid_q;
	logic [VAL_W-1:0]       tval_q;
	logic [SEED_W-1:0]      v_q;
	logic [CW-1:0]          cnt_q;
	logic                   done_q;
	logic [VAL_W-1:0]       rand_value_q;

	logic                   accept;
	logic [SEED_W-1:0]      seed_fix;
	logic [SEED_W-1:0]      x1;
	logic [VAL_W-1:0]       y1;
	logic [VAL_W-1:0]       y2;
	logic                   ram_we;
	logic [IW-1:0]          ram_waddr;
	logic [VAL_W-1:0]       ram_wdata;
	logic                   ram_re;
	logic [VAL_W-1:0]       ram_rdata;
	logic                   seed_wr;
	logic [31:0]            diff;
	logic [31:0]            wrapped;
	logic                   slot_go;
	logic                   slot_vld;
	logic [IW-1:0]          slot_idx;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign seed_fix = (seed_value == '0) ? SEED_W'(1) : seed_value;

	// generator one takes the seed on a seed request, then its own running value
	always_comb begin
		priority if (state_q == ST_IDLE && func == FN_SEED) begin
			x1 = seed_fix;
		end else if (state_q == ST_IDLE) begin
			x1 = SEED_W'(first_gen_q);
		end else begin
			x1 = v_q;
		end
	end

	lcsp_mcg u_mcg (
		.clk (clk),
		.x1  (x1),
		.x2  (second_gen_q),
		.y1  (y1),
		.y2  (y2)
	);

	// table: read at acceptance of a draw, written back at the output step of the draw;
	// one request at a time, so a read never overlaps a pending write
	assign seed_wr   = (state_q == ST_SEED_FOLD) && (cnt_q < CW'(TABLE_DEPTH));
	assign ram_we    = seed_wr || (state_q == ST_DRAW_OUT);
	assign ram_waddr = (state_q == ST_DRAW_OUT) ? slot_q : IW'(cnt_q);
	assign ram_wdata = (state_q == ST_DRAW_OUT) ? first_gen_q : y1;
	assign ram_re    = accept && (func == FN_DRAW);

	lcsp_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// difference of table entry and second generator, wrapped into 1..wrap
	assign diff    = {1'b0, tval_q} - {1'b0, second_gen_q};
	assign wrapped = ($signed(diff) < 32'sd1) ? diff + 32'(WRAP1) : diff;

	assign slot_go = (state_q == ST_SLOT_GO);

	lcsp_slot #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_slot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (slot_go),
		.x         (last_out_q),
		.out_valid (slot_vld),
		.idx       (slot_idx)
	);

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_gen_q  <= '0;
			second_gen_q <= '0;
			last_out_q   <= '0;
			slot_q       <= '0;
			valid_q      <= '0;
			cnt_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (func == FN_DRAW) ? ST_DRAW : ST_SEED_FOLD;
						cnt_q   <= CW'(TABLE_DEPTH + 7);
					end
				end
				ST_SEED_FOLD: begin
					if (cnt_q == '0) begin
						// last warm-up value is both slot zero and the output
						first_gen_q  <= y1;
						last_out_q   <= y1;
						second_gen_q <= SECOND_SEED;
						state_q      <= ST_SLOT_GO;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= ST_SEED_MUL;
					end
				end
				ST_SEED_MUL: begin
					state_q <= ST_SEED_FOLD;
				end
				ST_DRAW: begin
					first_gen_q  <= y1;
					second_gen_q <= y2;
					state_q      <= ST_DRAW_OUT;
				end
				ST_DRAW_OUT: begin
					last_out_q <= VAL_W'(wrapped);
					done_q     <= 1'b1;
					state_q    <= ST_SLOT_GO;
				end
				ST_SLOT_GO: begin
					state_q <= ST_SLOT_WAIT;
				end
				ST_SLOT_WAIT: begin
					if (slot_vld) begin
						slot_q  <= slot_idx;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_valid_q <= valid_q[slot_q];
		end
		if (state_q == ST_DRAW) begin
			// unwritten entry reads as its reset value of zero
			tval_q <= rd_valid_q ? ram_rdata : '0;
		end
		if (state_q == ST_SEED_FOLD) begin
			v_q <= SEED_W'(y1);
		end
		if (state_q == ST_DRAW_OUT) begin
			rand_value_q <= VAL_W'(wrapped);
		end
	end

	assign done       = done_q;
	assign rand_value = rand_value_q;

	// a result only follows the output step of a draw
	a_done_after_draw: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DRAW_OUT))
		else $error("result without a draw");

	// an accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request accepted but block not busy");

	// drawn value always lies in 1..wrap
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rand_value != '0) && (rand_value <= WRAP1))
		else $error("drawn value out of range");

	// table is written only while seeding or on the output step of a draw
	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_SEED_FOLD) || (state_q == ST_DRAW_OUT))
		else $error("table written outside a seed or draw");

	// selected slot stays inside the table
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(slot_q) <= 32'(TABLE_DEPTH - 1))
		else $error("slot index beyond table");

endmodule

/* rtl/lcsp_ram.sv */
// generic single-port-write ram with registered read
module lcsp_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/lcsp_mcg.sv */
// step unit for both congruential generators: registered product, then fold and reduce
module lcsp_mcg import lcsp_pkg::*; (
	input  logic              clk,
	input  logic [SEED_W-1:0] x1,
	input  logic [VAL_W-1:0]  x2,
	output logic [VAL_W-1:0]  y1,
	output logic [VAL_W-1:0]  y2
);
	logic [PROD_W-1:0] p1_s1;
	logic [PROD_W-1:0] p2_s1;

	// 2^31 is congruent to 2^31 - m, so the high part folds down with a small multiply
	function automatic logic [VAL_W-1:0] fold(input logic [PROD_W-1:0] p,
						  input logic [VAL_W-1:0] m);
		logic [7:0]  c;
		logic [31:0] s;
		c = 8'(32'h8000_0000 - {1'b0, m});
		s = 32'(p[PROD_W-1:VAL_W]) * 32'(c) + 32'(p[VAL_W-1:0]);
		fold = (s >= {1'b0, m}) ? VAL_W'(s - {1'b0, m}) : VAL_W'(s);
	endfunction

	always_ff @(posedge clk) begin
		p1_s1 <= PROD_W'(x1) * PROD_W'(MUL1);
		p2_s1 <= PROD_W'(x2) * PROD_W'(MUL2);
	end

	assign y1 = fold(p1_s1, MOD1);
	assign y2 = fold(p2_s1, MOD2);

endmodule

/* rtl/lcsp_slot.sv */
// table slot from last output: reciprocal multiply, back-multiply, one-step correction
module lcsp_slot import lcsp_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [VAL_W-1:0] x,
	output logic             out_valid,
	output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] idx
);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam longint unsigned SLOT_DIV = 64'd1 + 64'(WRAP1) / 64'(TABLE_DEPTH);
	localparam int RECIP_SH = 40;
	localparam longint unsigned RECIP = (64'd1 << RECIP_SH) / SLOT_DIV;
	localparam int RW = $clog2(RECIP + 1);
	localparam int PW = VAL_W + RW;
	localparam int QW = $clog2(TABLE_DEPTH + 1);

	logic [PW-1:0]    prod_s1;
	logic [VAL_W-1:0] x_s1;
	logic             v_s1;
	logic [QW-1:0]    q_s2;
	logic [31:0]      m_s2;
	logic [VAL_W-1:0] x_s2;
	logic             v_s2;
	logic [QW-1:0]    q_est;
	logic [31:0]      rem;
	logic [QW-1:0]    q_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// estimate is the true quotient or one below it
	assign q_est = QW'(prod_s1 >> RECIP_SH);

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(x) * PW'(RECIP);
		x_s1    <= x;
		q_s2    <= q_est;
		m_s2    <= 32'(q_est) * 32'(SLOT_DIV);
		x_s2    <= x_s1;
	end

	always_comb begin
		rem   = 32'(x_s2) - m_s2;
		q_fix = (rem >= 32'(SLOT_DIV)) ? QW'(q_s2 + 1'b1) : q_s2;
		if (q_fix > QW'(TABLE_DEPTH - 1)) begin
			q_fix = QW'(TABLE_DEPTH - 1);
		end
	end

	assign idx       = IW'(q_fix);
	assign out_valid = v_s2;

endmodule
